/* rtl/owbm_pkg.sv */
// Shared types and constants for the single-wire bus master.
package owbm_pkg;

  localparam int unsigned CNT_W      = 10;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned BIT_IDX_W  = $clog2(BYTE_W);
  localparam int unsigned NUM_REGS   = 7;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned Q_DEPTH    = 2;
  localparam int unsigned Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [REG_IDX_W-1:0] REG_RST_LOW  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PRES     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RST_REC  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LONG     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SHORT    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_RSAMP    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RREC     = 3'd6;

  localparam logic [CNT_W-1:0] CFG_RESET [NUM_REGS] = '{
    CNT_W'(480), CNT_W'(60), CNT_W'(420), CNT_W'(60), CNT_W'(1), CNT_W'(13), CNT_W'(47)
  };

  typedef enum logic [1:0] {
    OP_RESET = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  // One classified tick, as queued between front and back.
  typedef struct packed {
    logic              start;
    op_e               op;
    logic [BYTE_W-1:0] tx_byte;
    logic              line_level;
  } tick_t;

endpackage

/* rtl/one_wire_bus_master_top.sv */
// Top level of the single-wire bus master: front decode, tick queue, slot engine.
//
//  channel   dir  beat                         tdata / tuser
//  s_axis    in   one bus tick                 tdata: tx_byte, line_level / tuser: cmd
//  m_axis    out  line and status for the tick tdata: drive_low, busy, done, presence, rx
//  cfg       in   register write               index 0..6, 10-bit value
//
// One beat in and one beat out per clock unless the output stalls; sustained rate is one tick per cycle.
// Each tick passes through the two-entry tick queue and then the output register.
// The slot engine handles each tick with one counter add and compare.
// Reset clears state and loads the default slot timings; no clearing pass.
// An output stall fills the queue, then drops s_axis_tready.
module one_wire_bus_master_top import owbm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,   // [7:0] tx_byte, [8] line_level
  input  logic [2:0]           s_axis_tuser,   // [0] cmd_valid, [2:1] opcode
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,   // [0] drive_low, [1] busy_res,
                                               // [2] done_res, [3] presence, [11:4] rx_byte
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [CNT_W-1:0]     cfg_data_i
);

  logic              head_valid;
  tick_t             head;
  logic              pop;
  logic              drive_low;
  logic              busy_res;
  logic              done_res;
  logic              presence;
  logic [BYTE_W-1:0] rx_byte;

  owbm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .cmd_valid_i  (s_axis_tuser[0]),
    .opcode_i     (s_axis_tuser[2:1]),
    .tx_byte_i    (s_axis_tdata[7:0]),
    .line_level_i (s_axis_tdata[8]),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  owbm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .drive_low_o  (drive_low),
    .busy_res_o   (busy_res),
    .done_res_o   (done_res),
    .presence_o   (presence),
    .rx_byte_o    (rx_byte)
  );

  assign m_axis_tdata = {4'b0000, rx_byte, presence, done_res, busy_res, drive_low};

endmodule

/* rtl/owbm_front.sv */
// Front end: accepts ticks, decodes the command and queues them for the engine.
module owbm_front import owbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_valid_i,
  input  logic [1:0]  opcode_i,
  input  logic [BYTE_W-1:0] tx_byte_i,
  input  logic        line_level_i,
  input  logic        pop_i,
  output logic        head_valid_o,
  output tick_t       head_o
);

  tick_t               entry_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0]  count_q, count_d;
  tick_t               item;
  logic                push;
  logic                is_cmd;

  assign is_cmd = cmd_valid_i && (opcode_i inside {OP_RESET, OP_WRITE, OP_READ});

  always_comb begin
    item.start      = is_cmd;
    item.op         = is_cmd ? op_e'(opcode_i) : OP_RESET;
    item.tx_byte    = tx_byte_i;
    item.line_level = line_level_i;
  end

  assign in_ready_o   = (count_q != Q_CNT_W'(Q_DEPTH));
  assign push         = in_valid_i && in_ready_o;
  assign head_valid_o = (count_q != '0);
  assign head_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count over depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");

endmodule

/* rtl/owbm_back.sv */
// Back end: slot timing engine, configuration registers and output register.
module owbm_back import owbm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CNT_W-1:0]      cfg_data_i,
  input  logic                  head_valid_i,
  input  tick_t                 head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  drive_low_o,
  output logic                  busy_res_o,
  output logic                  done_res_o,
  output logic                  presence_o,
  output logic [BYTE_W-1:0]     rx_byte_o
);

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_REC  = 4'd3,
    PH_W_LOW    = 4'd4,
    PH_W_HIGH   = 4'd5,
    PH_R_LOW    = 4'd6,
    PH_R_WAIT   = 4'd7,
    PH_R_REC    = 4'd8
  } phase_e;

  logic [CNT_W-1:0]     cfg_q [NUM_REGS];
  phase_e               phase_q, phase_d;
  logic [CNT_W-1:0]     tick_q, tick_d;
  logic [BIT_IDX_W-1:0] bit_q, bit_d;
  logic [BYTE_W-1:0]    shift_q, shift_d;
  logic                 pres_q, pres_d;
  logic [BYTE_W-1:0]    rx_q, rx_d;
  logic                 done_d;
  logic                 out_valid_q;
  logic                 drive_q, busy_q, done_q;
  logic                 take;
  logic                 is_idle;
  logic [CNT_W-1:0]     next_cnt;
  logic [CNT_W-1:0]     len_raw, len;
  logic                 phase_end;

  assign take  = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = take;

  assign is_idle = !(phase_q inside {[PH_RST_LOW:PH_R_REC]});

  always_comb begin
    case (phase_q)
      PH_RST_LOW:  len_raw = cfg_q[REG_RST_LOW];
      PH_RST_WAIT: len_raw = cfg_q[REG_PRES];
      PH_RST_REC:  len_raw = cfg_q[REG_RST_REC];
      PH_W_LOW:    len_raw = shift_q[0] ? cfg_q[REG_SHORT] : cfg_q[REG_LONG];
      PH_W_HIGH:   len_raw = shift_q[0] ? cfg_q[REG_LONG] : cfg_q[REG_SHORT];
      PH_R_LOW:    len_raw = cfg_q[REG_SHORT];
      PH_R_WAIT:   len_raw = cfg_q[REG_RSAMP];
      PH_R_REC:    len_raw = cfg_q[REG_RREC];
      default:     len_raw = CNT_W'(1);
    endcase
  end

  assign len       = (len_raw == '0) ? CNT_W'(1) : len_raw;
  assign next_cnt  = tick_q + CNT_W'(1);
  assign phase_end = (next_cnt >= len) || (next_cnt == '0);

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    pres_d  = pres_q;
    rx_d    = rx_q;
    done_d  = 1'b0;
    if (take) begin
      if (is_idle) begin
        phase_d = PH_IDLE;
        if (head_i.start) begin
          tick_d = '0;
          bit_d  = '0;
          case (head_i.op)
            OP_RESET: begin
              phase_d = PH_RST_LOW;
            end
            OP_WRITE: begin
              shift_d = head_i.tx_byte;
              phase_d = PH_W_LOW;
            end
            default: begin
              shift_d = '0;
              phase_d = PH_R_LOW;
            end
          endcase
        end
      end else if (phase_end) begin
        tick_d = '0;
        case (phase_q)
          PH_RST_LOW: begin
            phase_d = PH_RST_WAIT;
          end
          PH_RST_WAIT: begin
            pres_d  = !head_i.line_level;
            phase_d = PH_RST_REC;
          end
          PH_RST_REC: begin
            phase_d = PH_IDLE;
            done_d  = 1'b1;
          end
          PH_W_LOW: begin
            phase_d = PH_W_HIGH;
          end
          PH_W_HIGH: begin
            if (bit_q == BIT_IDX_W'(BYTE_W - 1)) begin
              phase_d = PH_IDLE;
              done_d  = 1'b1;
            end else begin
              bit_d   = bit_q + 1'b1;
              shift_d = shift_q >> 1;
              phase_d = PH_W_LOW;
            end
          end
          PH_R_LOW: begin
            phase_d = PH_R_WAIT;
          end
          PH_R_WAIT: begin
            shift_d = {head_i.line_level, shift_q[BYTE_W-1:1]};
            phase_d = PH_R_REC;
          end
          default: begin
            if (bit_q == BIT_IDX_W'(BYTE_W - 1)) begin
              rx_d    = shift_q;
              phase_d = PH_IDLE;
              done_d  = 1'b1;
            end else begin
              bit_d   = bit_q + 1'b1;
              phase_d = PH_R_LOW;
            end
          end
        endcase
      end else begin
        tick_d = next_cnt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_q[i] <= CFG_RESET[i];
      end
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      pres_q      <= 1'b0;
      rx_q        <= '0;
      out_valid_q <= 1'b0;
      drive_q     <= 1'b0;
      busy_q      <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i < REG_IDX_W'(NUM_REGS))) begin
        cfg_q[cfg_idx_i] <= cfg_data_i;
      end
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      pres_q  <= pres_d;
      rx_q    <= rx_d;
      if (take) begin
        out_valid_q <= 1'b1;
        drive_q     <= (phase_d == PH_RST_LOW) || (phase_d == PH_W_LOW) ||
                       (phase_d == PH_R_LOW);
        busy_q      <= (phase_d != PH_IDLE);
        done_q      <= done_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_low_o = drive_q;
  assign busy_res_o  = busy_q;
  assign done_res_o  = done_q;
  assign presence_o  = pres_q;
  assign rx_byte_o   = rx_q;

  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && drive_q |-> busy_q)
    else $error("line driven outside a command");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q |-> !busy_q)
    else $error("done while busy");

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_q != '0 |-> phase_q != PH_IDLE)
    else $error("slot counter running while idle");

endmodule

/* sim/tb_one_wire_bus_master_top.sv */
// Self-checking testbench for one_wire_bus_master_top: per-tick bus model, random traffic, stalls.
`timescale 1ns / 100ps

module tb_one_wire_bus_master_top;
  import owbm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam logic [1:0] OPC_UNUSED = 2'd3;
  localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(BYTE_W - 1);

  typedef enum logic [3:0] {
    BUS_IDLE, BUS_RST_LOW, BUS_RST_WAIT, BUS_RST_REC,
    BUS_W_LOW, BUS_W_HIGH, BUS_R_LOW, BUS_R_WAIT, BUS_R_REC
  } bus_phase_e;

  typedef struct packed {
    logic              drive_low;
    logic              busy;
    logic              done;
    logic              presence;
    logic [BYTE_W-1:0] rx_byte;
  } bus_status_t;

  typedef logic [NUM_REGS-1:0][CNT_W-1:0] timing_set_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata = '0;
  logic [2:0]           s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;
  logic                 cfg_we_i = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CNT_W-1:0]     cfg_data_i = '0;

  // bus model state
  logic [CNT_W-1:0]     slot_cfg [NUM_REGS];
  bus_phase_e           bus_phase = BUS_IDLE;
  logic [CNT_W-1:0]     slot_count = '0;
  logic [BIT_IDX_W-1:0] bit_pos = '0;
  logic [BYTE_W-1:0]    shift_reg = '0;
  logic                 presence_seen = 1'b0;
  logic [BYTE_W-1:0]    rx_held = '0;

  bus_status_t          expected_status_q [$];
  bus_status_t          want;
  bit                   idling_on = 1'b1;
  int unsigned          hold_off_cycles = 0;
  int unsigned          rx_gap = 0;
  int unsigned          ticks_sent = 0;
  int unsigned          cycle_count = 0;
  int unsigned          errors = 0;

  one_wire_bus_master_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("one_wire_bus_master_top test failed");
      $finish;
    end
  end

  // receiver: long hold-off on request, short random gaps while idling is on
  always @(posedge clk_i) begin
    if (hold_off_cycles != 0) begin
      m_axis_tready <= 1'b0;
      hold_off_cycles--;
    end else if (rx_gap != 0) begin
      m_axis_tready <= 1'b0;
      rx_gap--;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      rx_gap = $urandom_range(0, 3);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [7:0] expv, input logic [7:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s expected %h got %h", $time, name, expv, actv);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_status_q.size() == 0) begin
        $display("%0t: beat with nothing expected, expected none got %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = expected_status_q.pop_front();
        check_field("drive_low", 8'(want.drive_low), 8'(m_axis_tdata[0]));
        check_field("busy", 8'(want.busy), 8'(m_axis_tdata[1]));
        check_field("done", 8'(want.done), 8'(m_axis_tdata[2]));
        check_field("presence", 8'(want.presence), 8'(m_axis_tdata[3]));
        check_field("rx_byte", want.rx_byte, m_axis_tdata[11:4]);
      end
    end
  end

  function automatic logic [CNT_W-1:0] phase_ticks(input bus_phase_e ph);
    logic [CNT_W-1:0] d;
    case (ph)
      BUS_RST_LOW:  d = slot_cfg[REG_RST_LOW];
      BUS_RST_WAIT: d = slot_cfg[REG_PRES];
      BUS_RST_REC:  d = slot_cfg[REG_RST_REC];
      BUS_W_LOW:    d = shift_reg[0] ? slot_cfg[REG_SHORT] : slot_cfg[REG_LONG];
      BUS_W_HIGH:   d = shift_reg[0] ? slot_cfg[REG_LONG] : slot_cfg[REG_SHORT];
      BUS_R_LOW:    d = slot_cfg[REG_SHORT];
      BUS_R_WAIT:   d = slot_cfg[REG_RSAMP];
      BUS_R_REC:    d = slot_cfg[REG_RREC];
      default:      d = CNT_W'(1);
    endcase
    if (d == '0) d = CNT_W'(1);
    return d;
  endfunction

  // advances the bus model by one tick and returns the status it shows
  function automatic bus_status_t bus_tick(input logic cmd, input logic [1:0] opc,
                                           input logic [7:0] tx, input logic line);
    logic [CNT_W-1:0] nxt;
    logic             fin;
    bus_status_t      r;
    fin = 1'b0;
    if (bus_phase == BUS_IDLE) begin
      if (cmd && opc != OPC_UNUSED) begin
        slot_count = '0;
        bit_pos = '0;
        case (opc)
          OP_RESET: bus_phase = BUS_RST_LOW;
          OP_WRITE: begin
            shift_reg = tx;
            bus_phase = BUS_W_LOW;
          end
          default: begin
            shift_reg = '0;
            bus_phase = BUS_R_LOW;
          end
        endcase
      end
    end else begin
      nxt = slot_count + 1'b1;
      if (nxt >= phase_ticks(bus_phase) || nxt == '0) begin
        slot_count = '0;
        case (bus_phase)
          BUS_RST_LOW: bus_phase = BUS_RST_WAIT;
          BUS_RST_WAIT: begin
            presence_seen = ~line;
            bus_phase = BUS_RST_REC;
          end
          BUS_RST_REC: begin
            bus_phase = BUS_IDLE;
            fin = 1'b1;
          end
          BUS_W_LOW: bus_phase = BUS_W_HIGH;
          BUS_W_HIGH: begin
            if (bit_pos == LAST_BIT) begin
              bus_phase = BUS_IDLE;
              fin = 1'b1;
            end else begin
              bit_pos++;
              shift_reg = shift_reg >> 1;
              bus_phase = BUS_W_LOW;
            end
          end
          BUS_R_LOW: bus_phase = BUS_R_WAIT;
          BUS_R_WAIT: begin
            shift_reg = {line, shift_reg[BYTE_W-1:1]};
            bus_phase = BUS_R_REC;
          end
          default: begin
            if (bit_pos == LAST_BIT) begin
              rx_held = shift_reg;
              bus_phase = BUS_IDLE;
              fin = 1'b1;
            end else begin
              bit_pos++;
              bus_phase = BUS_R_LOW;
            end
          end
        endcase
      end else begin
        slot_count = nxt;
      end
    end
    r.drive_low = (bus_phase == BUS_RST_LOW) || (bus_phase == BUS_W_LOW) ||
                  (bus_phase == BUS_R_LOW);
    r.busy = (bus_phase != BUS_IDLE);
    r.done = fin;
    r.presence = presence_seen;
    r.rx_byte = rx_held;
    return r;
  endfunction

  // line level a device would show on the next tick
  function automatic logic bus_level(input logic [7:0] dev_byte, input logic dev_present);
    case (bus_phase)
      BUS_RST_WAIT: return ~dev_present;
      BUS_R_WAIT:   return dev_byte[bit_pos];
      default:      return 1'($urandom_range(0, 1));
    endcase
  endfunction

  function automatic timing_set_t random_timing();
    timing_set_t t;
    for (int i = 0; i < NUM_REGS; i++) begin
      case ($urandom_range(0, 9))
        0:       t[i] = '0;
        1:       t[i] = CNT_W'($urandom_range(5, 12));
        default: t[i] = CNT_W'($urandom_range(1, 4));
      endcase
    end
    return t;
  endfunction

  function automatic timing_set_t default_timing();
    timing_set_t t;
    for (int i = 0; i < NUM_REGS; i++) t[i] = CFG_RESET[i];
    return t;
  endfunction

  task automatic send_tick(input logic cmd, input logic [1:0] opc, input logic [7:0] tx,
                           input logic line);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, line, tx};
    s_axis_tuser <= {opc, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_status_q.push_back(bus_tick(cmd, opc, tx, line));
    ticks_sent++;
  endtask

  // one command plus ticks until the model is idle again; noisy adds commands while busy
  task automatic run_cmd(input logic [1:0] opc, input logic [7:0] tx, input logic [7:0] dev_byte,
                         input logic dev_present, input bit noisy);
    send_tick(1'b1, opc, tx, bus_level(dev_byte, dev_present));
    while (bus_phase != BUS_IDLE)
      send_tick(noisy && ($urandom_range(0, 3) == 0), 2'($urandom_range(0, 3)),
                8'($urandom_range(0, 255)), bus_level(dev_byte, dev_present));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_timing(input timing_set_t vals);
    drain_results();
    repeat (4) @(posedge clk_i);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= REG_IDX_W'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      slot_cfg[i] = vals[i];
    end
    cfg_we_i <= 1'b0;
  endtask

  // first ticks of a command at the present timing, the rest at one-tick timing
  task automatic run_cmd_cut(input logic [1:0] opc, input logic [7:0] tx,
                             input logic [7:0] dev_byte, input logic dev_present,
                             input int unsigned n);
    send_tick(1'b1, opc, tx, bus_level(dev_byte, dev_present));
    repeat (n) begin
      if (bus_phase != BUS_IDLE)
        send_tick(1'b0, OP_RESET, 8'h00, bus_level(dev_byte, dev_present));
    end
    program_timing({NUM_REGS{CNT_W'(1)}});
    while (bus_phase != BUS_IDLE)
      send_tick(1'b0, OP_RESET, 8'h00, bus_level(dev_byte, dev_present));
  endtask

  task automatic test_default_timing();
    idling_on = 1'b1;
    run_cmd_cut(OP_WRITE, 8'hFE, 8'h00, 1'b0, 63);
    program_timing(default_timing());
    run_cmd_cut(OP_READ, 8'h00, 8'hA5, 1'b1, 65);
    program_timing(default_timing());
    run_cmd_cut(OP_RESET, 8'h00, 8'h00, 1'b1, 40);
    send_tick(1'b1, OPC_UNUSED, 8'hFF, 1'b1);
  endtask

  task automatic test_zero_and_min_timing();
    program_timing('0);
    run_cmd(OP_RESET, 8'h00, 8'h00, 1'b1, 1'b1);
    run_cmd(OP_WRITE, 8'h5A, 8'h00, 1'b0, 1'b1);
    run_cmd(OP_READ, 8'h00, 8'hC3, 1'b1, 1'b1);
    program_timing({NUM_REGS{CNT_W'(1)}});
    run_cmd(OP_RESET, 8'h00, 8'h00, 1'b0, 1'b1);
    run_cmd(OP_WRITE, 8'hA5, 8'h00, 1'b0, 1'b0);
    run_cmd(OP_READ, 8'h00, 8'h3C, 1'b1, 1'b1);
  endtask

  task automatic test_max_timing();
    program_timing({NUM_REGS{CNT_W'(1023)}});
    run_cmd_cut(OP_RESET, 8'h00, 8'h00, 1'b1, 20);
    program_timing({NUM_REGS{CNT_W'(1023)}});
    run_cmd_cut(OP_WRITE, 8'h81, 8'h00, 1'b1, 20);
    program_timing({NUM_REGS{CNT_W'(1023)}});
    run_cmd_cut(OP_READ, 8'h00, 8'h7E, 1'b1, 20);
  endtask

  task automatic test_output_backpressure();
    program_timing(random_timing());
    hold_off_cycles = 100;
    run_cmd(OP_READ, 8'h00, 8'h96, 1'b1, 1'b1);
    run_cmd(OP_WRITE, 8'($urandom_range(0, 255)), 8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_sender_pause();
    repeat (2) begin
      run_cmd(2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), 1'b1);
      drain_results();
    end
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    int unsigned next_cfg;
    start = ticks_sent;
    next_cfg = 0;
    while (ticks_sent - start < 150) begin
      if (ticks_sent - start >= next_cfg) begin
        program_timing(random_timing());
        next_cfg += 75;
      end
      case ($urandom_range(0, 9))
        0: send_tick(1'b0, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
        1: send_tick(1'b1, OPC_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        default: run_cmd(2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  task automatic test_steady_stream();
    program_timing(random_timing());
    idling_on = 1'b0;
    run_cmd(OP_RESET, 8'h00, 8'h00, 1'b1, 1'b1);
    run_cmd(OP_WRITE, 8'($urandom_range(0, 255)), 8'h00, 1'b0, 1'b1);
    run_cmd(OP_READ, 8'h00, 8'($urandom_range(0, 255)), 1'b1, 1'b1);
    send_tick(1'b1, OPC_UNUSED, 8'h00, 1'b0);
  endtask

  initial begin
    for (int i = 0; i < NUM_REGS; i++) slot_cfg[i] = CFG_RESET[i];
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_timing();
    test_zero_and_min_timing();
    test_max_timing();
    test_output_backpressure();
    test_sender_pause();
    test_random_traffic();
    test_steady_stream();
    drain_results();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("one_wire_bus_master_top test passed");
    end else begin
      $display("one_wire_bus_master_top test failed");
    end
    $finish;
  end

endmodule
